// File: src/trqs_pkg.sv
// Package for the thread run-queue scheduler: slot states, wait kinds,
// command and reason codes, datapath operation, sequencer state and status types.
// No dependencies.
package trqs_pkg;

   localparam int SLOTS_DEFAULT = 32;
   localparam int TICK_WIDTH_DEFAULT = 16;

   typedef enum logic [1:0] {
      ST_FIN  = 2'd0,
      ST_RDY  = 2'd1,
      ST_RUN  = 2'd2,
      ST_WAIT = 2'd3
   } slot_state_type;

   localparam logic [1:0] WK_NONE  = 2'd0;
   localparam logic [1:0] WK_UART  = 2'd1;
   localparam logic [1:0] WK_TIMER = 2'd2;

   localparam logic [2:0] CMD_SCHEDULE = 3'd0;
   localparam logic [2:0] CMD_CREATE   = 3'd1;
   localparam logic [2:0] CMD_UART     = 3'd2;
   localparam logic [2:0] CMD_TICK     = 3'd3;
   localparam logic [2:0] CMD_SLP_UART = 3'd4;
   localparam logic [2:0] CMD_SLP_TMR  = 3'd5;

   localparam logic [1:0] RSN_PREEMPT = 2'd0;
   localparam logic [1:0] RSN_WAIT    = 2'd1;
   localparam logic [1:0] RSN_FINISH  = 2'd2;

   // Operations the controller asks of the datapath, one per cycle.
   typedef enum logic [4:0] {
      OP_NONE,
      OP_LATCH,       // capture command, point cursor at head
      OP_PICK_STEP,   // walk past a waiting slot
      OP_PICK_END,    // decide on the slot under the cursor
      OP_FRONT_UNL,   // unlink the cursor slot
      OP_FRONT_INS,   // insert cursor slot before head, head := next
      OP_SW_DECIDE,   // decide switch, update old thread state
      OP_END_INIT,    // cursor := prev of old thread
      OP_END_STEP,    // walk the requeue search back
      OP_END_UNL,     // unlink old thread
      OP_END_INS,     // relink old thread
      OP_SW_FINISH,   // mark new thread running
      OP_CR_P1,       // cursor := prev of head
      OP_CR_P2,       // cursor := prev of cursor, test finished
      OP_CR_UNL,      // unlink created slot
      OP_CR_INS,      // insert before head
      OP_UART_STEP,   // uart wake walk
      OP_TICK_STEP,   // timer tick walk
      OP_SLEEP,       // sleep commands
      OP_RESULT       // show result
   } op_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_LATCH,
      S_PICK,
      S_PICK_END,
      S_PF_UNL,
      S_PF_INS,
      S_SW,
      S_END_INIT,
      S_END_WALK,
      S_END_UNL,
      S_END_INS,
      S_SW_FIN,
      S_CR1,
      S_CR2,
      S_CR_UNL,
      S_CR_INS,
      S_UART,
      S_TICK,
      S_SLEEP,
      S_RESULT
   } seq_state_type;

   // Status from the datapath back to the controller.
   typedef struct packed {
      logic [2:0] cmd;
      logic       cur_wait;    // cursor slot waiting
      logic       walk_left;   // step count below pool size
      logic       pick_ready;  // cursor slot ready
      logic       pick_move;   // cursor slot differs from head
      logic       sw_go;       // a switch happens
      logic       sw_requeue;  // old thread gets requeued
      logic       end_more;    // requeue search continues
      logic       cr_found;    // create slot finished
      logic       cr_move;     // create slot differs from head
      logic       uart_more;   // uart walk continues
      logic       tick_more;   // tick walk continues
   } status_type;

endpackage

// File: src/trqs_ctrl.sv
// Sequencer for the thread run-queue scheduler.
// Depends on trqs_pkg.
module trqs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  trqs_pkg::status_type   status,
   output trqs_pkg::op_type       op,
   output logic                   busy
);

   trqs_pkg::seq_state_type state_ff, state_in;

   // Hold the sequencer state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= trqs_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Choose the next step and the datapath operation.
   always_comb begin
      state_in = state_ff;
      op = trqs_pkg::OP_NONE;
      busy = 1'b1;
      unique case (state_ff)
         trqs_pkg::S_IDLE: begin
            busy = 1'b0;
            // capture the command at the accepting edge
            if (start) begin
               op = trqs_pkg::OP_LATCH;
               state_in = trqs_pkg::S_LATCH;
            end
         end
         trqs_pkg::S_LATCH: begin
            op = trqs_pkg::OP_NONE;
            state_in = trqs_pkg::S_SLEEP;
         end
         trqs_pkg::S_SLEEP: begin
            // dispatch on the latched command
            op = trqs_pkg::OP_NONE;
            case (status.cmd) inside
               trqs_pkg::CMD_SCHEDULE: state_in = trqs_pkg::S_PICK;
               trqs_pkg::CMD_CREATE:   state_in = trqs_pkg::S_CR1;
               trqs_pkg::CMD_UART:     state_in = trqs_pkg::S_UART;
               trqs_pkg::CMD_TICK:     state_in = trqs_pkg::S_TICK;
               trqs_pkg::CMD_SLP_UART, trqs_pkg::CMD_SLP_TMR: begin
                  op = trqs_pkg::OP_SLEEP;
                  state_in = trqs_pkg::S_RESULT;
               end
               default: state_in = trqs_pkg::S_RESULT;
            endcase
         end
         trqs_pkg::S_PICK: begin
            if (status.cur_wait && status.walk_left) begin
               op = trqs_pkg::OP_PICK_STEP;
            end else begin
               state_in = trqs_pkg::S_PICK_END;
            end
         end
         trqs_pkg::S_PICK_END: begin
            op = trqs_pkg::OP_PICK_END;
            if (status.pick_ready && status.pick_move) begin
               state_in = trqs_pkg::S_PF_UNL;
            end else begin
               state_in = trqs_pkg::S_SW;
            end
         end
         trqs_pkg::S_PF_UNL: begin
            op = trqs_pkg::OP_FRONT_UNL;
            state_in = trqs_pkg::S_PF_INS;
         end
         trqs_pkg::S_PF_INS: begin
            op = trqs_pkg::OP_FRONT_INS;
            state_in = trqs_pkg::S_SW;
         end
         trqs_pkg::S_SW: begin
            op = trqs_pkg::OP_SW_DECIDE;
            if (!status.sw_go) begin
               state_in = trqs_pkg::S_RESULT;
            end else if (status.sw_requeue) begin
               state_in = trqs_pkg::S_END_INIT;
            end else begin
               state_in = trqs_pkg::S_SW_FIN;
            end
         end
         trqs_pkg::S_END_INIT: begin
            op = trqs_pkg::OP_END_INIT;
            state_in = trqs_pkg::S_END_WALK;
         end
         trqs_pkg::S_END_WALK: begin
            if (status.end_more) begin
               op = trqs_pkg::OP_END_STEP;
            end else begin
               state_in = trqs_pkg::S_END_UNL;
            end
         end
         trqs_pkg::S_END_UNL: begin
            op = trqs_pkg::OP_END_UNL;
            state_in = trqs_pkg::S_END_INS;
         end
         trqs_pkg::S_END_INS: begin
            op = trqs_pkg::OP_END_INS;
            state_in = trqs_pkg::S_SW_FIN;
         end
         trqs_pkg::S_SW_FIN: begin
            op = trqs_pkg::OP_SW_FINISH;
            state_in = trqs_pkg::S_RESULT;
         end
         trqs_pkg::S_CR1: begin
            op = trqs_pkg::OP_CR_P1;
            state_in = trqs_pkg::S_CR2;
         end
         trqs_pkg::S_CR2: begin
            op = trqs_pkg::OP_CR_P2;
            if (status.cr_found && status.cr_move) begin
               state_in = trqs_pkg::S_CR_UNL;
            end else begin
               state_in = trqs_pkg::S_RESULT;
            end
         end
         trqs_pkg::S_CR_UNL: begin
            op = trqs_pkg::OP_CR_UNL;
            state_in = trqs_pkg::S_CR_INS;
         end
         trqs_pkg::S_CR_INS: begin
            op = trqs_pkg::OP_CR_INS;
            state_in = trqs_pkg::S_RESULT;
         end
         trqs_pkg::S_UART: begin
            op = trqs_pkg::OP_UART_STEP;
            if (!status.uart_more) begin
               state_in = trqs_pkg::S_RESULT;
            end
         end
         trqs_pkg::S_TICK: begin
            op = trqs_pkg::OP_TICK_STEP;
            if (!status.tick_more) begin
               state_in = trqs_pkg::S_RESULT;
            end
         end
         trqs_pkg::S_RESULT: begin
            op = trqs_pkg::OP_RESULT;
            state_in = trqs_pkg::S_IDLE;
         end
         default: state_in = trqs_pkg::S_IDLE;
      endcase
   end

   // Busy drops only in the idle state.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == trqs_pkg::S_IDLE) == !busy)
      else $error("busy does not track the idle state");
   // An accepted command always moves to latch.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> state_ff == trqs_pkg::S_LATCH)
      else $error("accepted command not latched");
   // The result step is followed by idle.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == trqs_pkg::S_RESULT) |=> !busy)
      else $error("result not followed by idle");

endmodule

// File: src/trqs_datapath.sv
// Slot tables, links, head, running thread and the walk cursor.
// Depends on trqs_pkg; driven by trqs_ctrl operations.
module trqs_datapath #(
   parameter int SLOTS = trqs_pkg::SLOTS_DEFAULT,
   parameter int TICK_WIDTH = trqs_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  trqs_pkg::op_type          op,
   input  logic [2:0]                cmd,
   input  logic [1:0]                reason,
   input  logic [15:0]               intervals,
   output trqs_pkg::status_type      status,
   output logic                      out_valid,
   output logic [$clog2(SLOTS):0]    out_current,
   output logic                      out_switched,
   output logic                      out_created_ok,
   output logic [$clog2(SLOTS)-1:0]  out_created_slot,
   output logic                      out_fault
);

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int RW = IW + 1;
   localparam int CW = $clog2(SLOTS + 1);
   localparam logic [RW-1:0] IDLE_ID = RW'(SLOTS);

   // Per-slot stores, indexed by the cursor, the head and the links.
   trqs_pkg::slot_state_type state_ff [SLOTS];
   logic [1:0]            kind_ff  [SLOTS];
   logic [TICK_WIDTH-1:0] ticks_ff [SLOTS];
   logic [IW-1:0]         next_ff  [SLOTS];
   logic [IW-1:0]         prev_ff  [SLOTS];
   logic [IW-1:0]         head_ff;
   logic [RW-1:0]         run_ff;

   // Command context and working registers.
   logic [2:0]            cmd_ff;
   logic [1:0]            rsn_ff;
   logic [15:0]           intv_ff;
   logic [IW-1:0]         cur_ff;     // walk cursor
   logic [CW-1:0]         cnt_ff;     // walk step count
   logic [RW-1:0]         nx_ff;      // selected thread or idle
   logic [IW-1:0]         old_ff;     // thread switched out
   logic                  sw_ff, cok_ff, flt_ff;
   logic [IW-1:0]         cslot_ff;
   logic                  ov_ff;

   logic [1:0] rsn_eff;
   logic       cur_idle;
   logic [IW-1:0] old_slot;
   logic       at_head;
   logic       end_skip;
   logic [TICK_WIDTH-1:0] dec_ticks;
   logic [IW-1:0] hp;

   assign rsn_eff  = (rsn_ff == 2'd3) ? trqs_pkg::RSN_PREEMPT : rsn_ff;
   assign cur_idle = (run_ff >= IDLE_ID);
   assign old_slot = run_ff[IW-1:0];
   assign at_head  = (cur_ff == head_ff);
   assign dec_ticks = ticks_ff[cur_ff] - TICK_WIDTH'(1);
   assign hp = prev_ff[head_ff];
   assign end_skip = (state_ff[cur_ff] == trqs_pkg::ST_FIN) ||
      (rsn_eff == trqs_pkg::RSN_WAIT && state_ff[cur_ff] == trqs_pkg::ST_RDY);

   // Status toward the controller.
   always_comb begin
      status.cmd        = cmd_ff;
      status.cur_wait   = (state_ff[cur_ff] == trqs_pkg::ST_WAIT);
      status.walk_left  = (cnt_ff < CW'(SLOTS));
      status.pick_ready = (state_ff[cur_ff] == trqs_pkg::ST_RDY);
      status.pick_move  = !at_head;
      status.sw_go      = !((nx_ff == IDLE_ID) && cur_idle) &&
                          !((rsn_eff == trqs_pkg::RSN_PREEMPT) && !cur_idle &&
                            (nx_ff == IDLE_ID)) &&
                          !((nx_ff != IDLE_ID) &&
                            (state_ff[nx_ff[IW-1:0]] != trqs_pkg::ST_RDY));
      status.sw_requeue = !cur_idle && (rsn_eff != trqs_pkg::RSN_FINISH);
      status.end_more   = (cnt_ff < CW'(SLOTS)) && !at_head && end_skip;
      status.cr_found   = (state_ff[prev_ff[cur_ff]] == trqs_pkg::ST_FIN);
      status.cr_move    = (prev_ff[cur_ff] != head_ff);
      status.uart_more  = (state_ff[cur_ff] == trqs_pkg::ST_WAIT) &&
                          (kind_ff[cur_ff] != trqs_pkg::WK_UART) &&
                          (cnt_ff < CW'(SLOTS));
      status.tick_more  = (state_ff[cur_ff] == trqs_pkg::ST_WAIT) &&
                          (cnt_ff + CW'(1) < CW'(SLOTS));
   end

   // Apply the operation chosen by the controller.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            state_ff[i] <= trqs_pkg::ST_FIN;
            kind_ff[i]  <= trqs_pkg::WK_NONE;
            ticks_ff[i] <= '0;
            next_ff[i]  <= IW'((i + 1) % SLOTS);
            prev_ff[i]  <= IW'((i + SLOTS - 1) % SLOTS);
         end
         head_ff <= '0;
         run_ff  <= IDLE_ID;
         ov_ff   <= 1'b0;
      end else begin
         ov_ff <= 1'b0;
         case (op) inside
            trqs_pkg::OP_LATCH: begin
               cmd_ff  <= cmd;
               rsn_ff  <= reason;
               intv_ff <= intervals;
               cur_ff  <= head_ff;
               cnt_ff  <= '0;
               sw_ff   <= 1'b0;
               cok_ff  <= 1'b0;
               flt_ff  <= 1'b0;
               cslot_ff <= '0;
            end
            trqs_pkg::OP_PICK_STEP: begin
               cur_ff <= next_ff[cur_ff];
               cnt_ff <= cnt_ff + CW'(1);
            end
            trqs_pkg::OP_PICK_END: begin
               if (state_ff[cur_ff] == trqs_pkg::ST_RDY) begin
                  nx_ff <= RW'(cur_ff);
                  if (at_head) begin
                     head_ff <= next_ff[cur_ff];
                  end
               end else begin
                  nx_ff <= IDLE_ID;
               end
            end
            trqs_pkg::OP_FRONT_UNL, trqs_pkg::OP_CR_UNL, trqs_pkg::OP_END_UNL: begin
               // unlink slot t (cursor, or old thread for the requeue)
               if (op == trqs_pkg::OP_END_UNL) begin
                  prev_ff[next_ff[old_ff]] <= prev_ff[old_ff];
                  next_ff[prev_ff[old_ff]] <= next_ff[old_ff];
               end else begin
                  prev_ff[next_ff[cur_ff]] <= prev_ff[cur_ff];
                  next_ff[prev_ff[cur_ff]] <= next_ff[cur_ff];
               end
            end
            trqs_pkg::OP_FRONT_INS, trqs_pkg::OP_CR_INS: begin
               next_ff[hp]      <= cur_ff;
               prev_ff[cur_ff]  <= hp;
               next_ff[cur_ff]  <= head_ff;
               prev_ff[head_ff] <= cur_ff;
               // schedule moves the head past the picked slot
               head_ff <= (op == trqs_pkg::OP_FRONT_INS) ? head_ff : cur_ff;
            end
            trqs_pkg::OP_SW_DECIDE: begin
               old_ff <= old_slot;
               if ((nx_ff != IDLE_ID) &&
                   (state_ff[nx_ff[IW-1:0]] != trqs_pkg::ST_RDY) &&
                   !((nx_ff == IDLE_ID) && cur_idle)) begin
                  flt_ff <= 1'b1;
               end
               if (status.sw_go && !cur_idle) begin
                  case (rsn_eff)
                     trqs_pkg::RSN_FINISH: state_ff[old_slot] <= trqs_pkg::ST_FIN;
                     trqs_pkg::RSN_WAIT:   state_ff[old_slot] <= trqs_pkg::ST_WAIT;
                     default:              state_ff[old_slot] <= trqs_pkg::ST_RDY;
                  endcase
               end
            end
            trqs_pkg::OP_END_INIT: begin
               cur_ff <= prev_ff[old_ff];
               cnt_ff <= '0;
            end
            trqs_pkg::OP_END_STEP: begin
               cur_ff <= prev_ff[cur_ff];
               cnt_ff <= cnt_ff + CW'(1);
            end
            trqs_pkg::OP_END_INS: begin
               if (at_head) begin
                  next_ff[hp]      <= old_ff;
                  prev_ff[old_ff]  <= hp;
                  next_ff[old_ff]  <= head_ff;
                  prev_ff[head_ff] <= old_ff;
                  head_ff          <= old_ff;
               end else begin
                  next_ff[old_ff]          <= next_ff[cur_ff];
                  prev_ff[old_ff]          <= cur_ff;
                  prev_ff[next_ff[cur_ff]] <= old_ff;
                  next_ff[cur_ff]          <= old_ff;
               end
            end
            trqs_pkg::OP_SW_FINISH: begin
               if (nx_ff != IDLE_ID) begin
                  state_ff[nx_ff[IW-1:0]] <= trqs_pkg::ST_RUN;
               end
               run_ff <= nx_ff;
               sw_ff  <= 1'b1;
            end
            trqs_pkg::OP_CR_P1: begin
               cur_ff <= hp;
            end
            trqs_pkg::OP_CR_P2: begin
               cur_ff <= prev_ff[cur_ff];
               if (status.cr_found) begin
                  state_ff[prev_ff[cur_ff]] <= trqs_pkg::ST_RDY;
                  cok_ff   <= 1'b1;
                  cslot_ff <= prev_ff[cur_ff];
                  flt_ff   <= !status.cr_move;
               end
            end
            trqs_pkg::OP_UART_STEP: begin
               if ((state_ff[cur_ff] == trqs_pkg::ST_WAIT) &&
                   (kind_ff[cur_ff] == trqs_pkg::WK_UART)) begin
                  state_ff[cur_ff] <= trqs_pkg::ST_RDY;
               end
               cur_ff <= next_ff[cur_ff];
               cnt_ff <= cnt_ff + CW'(1);
            end
            trqs_pkg::OP_TICK_STEP: begin
               if ((state_ff[cur_ff] == trqs_pkg::ST_WAIT) &&
                   (kind_ff[cur_ff] == trqs_pkg::WK_TIMER)) begin
                  ticks_ff[cur_ff] <= dec_ticks;
                  if (dec_ticks == '0) begin
                     state_ff[cur_ff] <= trqs_pkg::ST_RDY;
                  end
               end
               cur_ff <= next_ff[cur_ff];
               cnt_ff <= cnt_ff + CW'(1);
            end
            trqs_pkg::OP_SLEEP: begin
               if (cmd_ff == trqs_pkg::CMD_SLP_UART) begin
                  kind_ff[hp] <= trqs_pkg::WK_UART;
               end else begin
                  kind_ff[hp]  <= trqs_pkg::WK_TIMER;
                  ticks_ff[hp] <= TICK_WIDTH'(intv_ff);
               end
            end
            trqs_pkg::OP_RESULT: begin
               ov_ff <= 1'b1;
            end
            default: ;
         endcase
      end
   end

   assign out_valid        = ov_ff;
   assign out_current      = run_ff;
   assign out_switched     = sw_ff;
   assign out_created_ok   = cok_ff;
   assign out_created_slot = cslot_ff;
   assign out_fault        = flt_ff;

   // The running thread, when real, is marked running once a command ends.
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && (run_ff < IDLE_ID)) |-> state_ff[run_ff[IW-1:0]] == trqs_pkg::ST_RUN)
      else $error("running thread not in running state");
   // The head stays linked both ways.
   assert property (@(posedge clock) disable iff (reset)
      ov_ff |-> next_ff[prev_ff[head_ff]] == head_ff)
      else $error("head links broken");
   // A created slot is reported only with its ok flag.
   assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !cok_ff) |-> cslot_ff == '0)
      else $error("created slot without create");

endmodule

// File: src/thread_run_queue_scheduler.sv
// Thread run-queue scheduler over a fixed pool of slots.
//
// Usage: drive req_command, req_reason and req_intervals with start high;
// the command is taken at a clock edge where start is high and busy is low.
// Exactly one result follows for every command: rsp_valid is high for one
// cycle with rsp_current_thread, rsp_switched, rsp_created_ok,
// rsp_created_slot and rsp_fault. The receiver cannot stall this channel.
// Sleep and unused commands go straight to the result; create may move
// the new slot to the front; uart wake and timer tick walk the ring from
// the head; schedule walks past the waiting slots at the head, may move the
// picked slot to the front and, on a switch from a thread that does not
// finish, requeues that thread after a backward search. The walks step one
// link per cycle through the slot tables; one command is in flight at a
// time and the next is accepted at the earliest in the result cycle.
// Reset (synchronous, high) marks all slots finished, links them as a
// ring in slot order, sets the head to slot 0 and runs the idle thread.
module thread_run_queue_scheduler #(
   parameter int SLOTS = trqs_pkg::SLOTS_DEFAULT,
   parameter int TICK_WIDTH = trqs_pkg::TICK_WIDTH_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic [2:0]                req_command,
   input  logic [1:0]                req_reason,
   input  logic [15:0]               req_intervals,
   output logic                      rsp_valid,
   output logic [$clog2(SLOTS):0]    rsp_current_thread,
   output logic                      rsp_switched,
   output logic                      rsp_created_ok,
   output logic [$clog2(SLOTS)-1:0]  rsp_created_slot,
   output logic                      rsp_fault
);

   trqs_pkg::op_type     op;
   trqs_pkg::status_type status;

   trqs_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .op     (op),
      .busy   (busy)
   );

   trqs_datapath #(
      .SLOTS      (SLOTS),
      .TICK_WIDTH (TICK_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .op               (op),
      .cmd              (req_command),
      .reason           (req_reason),
      .intervals        (req_intervals),
      .status           (status),
      .out_valid        (rsp_valid),
      .out_current      (rsp_current_thread),
      .out_switched     (rsp_switched),
      .out_created_ok   (rsp_created_ok),
      .out_created_slot (rsp_created_slot),
      .out_fault        (rsp_fault)
   );

endmodule

// File: test/thread_run_queue_scheduler_tb.sv
`timescale 1ns / 1ps
// Testbench for thread_run_queue_scheduler: predicts each command's result with an
// in-bench model of the slot ring, drives commands with random gaps, checks every result.
// Depends on trqs_pkg and the scheduler RTL.
module thread_run_queue_scheduler_tb;

   localparam int NSLOT = 32;
   localparam logic [5:0] IDLE_SLOT = 6'd32;
   localparam int CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [2:0]  command;
      logic [1:0]  reason;
      logic [15:0] intervals;
   } cmd_item_type;

   typedef struct packed {
      logic [5:0] current_thread;
      logic       switched;
      logic       created_ok;
      logic [4:0] created_slot;
      logic       fault;
   } sched_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [2:0]  req_command = '0;
   logic [1:0]  req_reason = '0;
   logic [15:0] req_intervals = '0;
   logic        rsp_valid;
   logic [5:0]  rsp_current_thread;
   logic        rsp_switched;
   logic        rsp_created_ok;
   logic [4:0]  rsp_created_slot;
   logic        rsp_fault;

   // Predictor state: slot tables, ring links, head and running thread.
   trqs_pkg::slot_state_type st_tab[NSLOT];
   logic [1:0]     kind_tab[NSLOT];
   logic [15:0]    ticks_tab[NSLOT];
   logic [4:0]     fwd[NSLOT];
   logic [4:0]     bwd[NSLOT];
   logic [4:0]     head;
   logic [5:0]     running;

   cmd_item_type     pending_cmds[$];
   sched_result_type expected_results[$];
   int            errors = 0;
   int            cycles = 0;
   int            send_idle_pct = 28;
   logic          hold_send = 1'b0;
   logic          accepted = 1'b0;

   thread_run_queue_scheduler u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_reason(req_reason),
      .req_intervals(req_intervals), .rsp_valid(rsp_valid),
      .rsp_current_thread(rsp_current_thread), .rsp_switched(rsp_switched),
      .rsp_created_ok(rsp_created_ok), .rsp_created_slot(rsp_created_slot),
      .rsp_fault(rsp_fault)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic void ring_unlink(logic [4:0] t);
      logic [4:0] n, p;
      n = fwd[t];
      p = bwd[t];
      bwd[n] = p;
      fwd[p] = n;
   endfunction

   function automatic void ring_put_front(logic [4:0] t);
      logic [4:0] h;
      h = head;
      fwd[bwd[h]] = t;
      bwd[t] = bwd[h];
      fwd[t] = h;
      bwd[h] = t;
      head = t;
   endfunction

   function automatic bit ring_to_front(logic [4:0] t);
      if (t == head) return 1'b0;
      ring_unlink(t);
      ring_put_front(t);
      return 1'b1;
   endfunction

   // Requeue the old thread behind the last slot still in play.
   function automatic void ring_requeue(logic [4:0] t, bit waiting);
      logic [4:0] qe, after;
      int n;
      qe = bwd[t];
      n = 0;
      while (n < NSLOT && qe != head &&
             (st_tab[qe] == trqs_pkg::ST_FIN ||
              (waiting && st_tab[qe] == trqs_pkg::ST_RDY))) begin
         qe = bwd[qe];
         n++;
      end
      ring_unlink(t);
      if (qe == head) ring_put_front(t);
      else begin
         after = fwd[qe];
         fwd[t] = after;
         bwd[t] = qe;
         bwd[after] = t;
         fwd[qe] = t;
      end
   endfunction

   function automatic sched_result_type predict_command(cmd_item_type c);
      sched_result_type r;
      logic [4:0] s, p, cs;
      logic [5:0] nx, cur;
      logic [1:0] rsn;
      int n;
      r = '0;
      case (c.command)
         trqs_pkg::CMD_SCHEDULE: begin
            rsn = (c.reason > trqs_pkg::RSN_FINISH) ? trqs_pkg::RSN_PREEMPT : c.reason;
            s = head;
            n = 0;
            while (st_tab[s] == trqs_pkg::ST_WAIT && n < NSLOT) begin
               s = fwd[s];
               n++;
            end
            if (st_tab[s] != trqs_pkg::ST_RDY) nx = IDLE_SLOT;
            else begin
               if (s != head) void'(ring_to_front(s));
               head = fwd[s];
               nx = {1'b0, s};
            end
            cur = (running < NSLOT) ? running : IDLE_SLOT;
            if (!(nx == IDLE_SLOT && cur == IDLE_SLOT) &&
                !(rsn == trqs_pkg::RSN_PREEMPT && cur != IDLE_SLOT && nx == IDLE_SLOT)) begin
               if (nx != IDLE_SLOT && st_tab[nx[4:0]] != trqs_pkg::ST_RDY) r.fault = 1'b1;
               else begin
                  if (cur != IDLE_SLOT) begin
                     if (rsn == trqs_pkg::RSN_FINISH) st_tab[cur[4:0]] = trqs_pkg::ST_FIN;
                     else if (rsn == trqs_pkg::RSN_WAIT) begin
                        st_tab[cur[4:0]] = trqs_pkg::ST_WAIT;
                        ring_requeue(cur[4:0], 1'b1);
                     end else begin
                        st_tab[cur[4:0]] = trqs_pkg::ST_RDY;
                        ring_requeue(cur[4:0], 1'b0);
                     end
                  end
                  if (nx != IDLE_SLOT) st_tab[nx[4:0]] = trqs_pkg::ST_RUN;
                  running = nx;
                  r.switched = 1'b1;
               end
            end
         end
         trqs_pkg::CMD_CREATE: begin
            cs = bwd[bwd[head]];
            if (st_tab[cs] == trqs_pkg::ST_FIN) begin
               st_tab[cs] = trqs_pkg::ST_RDY;
               if (!ring_to_front(cs)) r.fault = 1'b1;
               r.created_ok = 1'b1;
               r.created_slot = cs;
            end
         end
         trqs_pkg::CMD_UART: begin
            p = head;
            n = 0;
            while (st_tab[p] == trqs_pkg::ST_WAIT && kind_tab[p] != trqs_pkg::WK_UART &&
                   n < NSLOT) begin
               p = fwd[p];
               n++;
            end
            if (st_tab[p] == trqs_pkg::ST_WAIT && kind_tab[p] == trqs_pkg::WK_UART)
               st_tab[p] = trqs_pkg::ST_RDY;
         end
         trqs_pkg::CMD_TICK: begin
            p = head;
            n = 0;
            while (st_tab[p] == trqs_pkg::ST_WAIT && n < NSLOT) begin
               if (kind_tab[p] == trqs_pkg::WK_TIMER) begin
                  ticks_tab[p] = ticks_tab[p] - 16'd1;
                  if (ticks_tab[p] == 16'd0) st_tab[p] = trqs_pkg::ST_RDY;
               end
               p = fwd[p];
               n++;
            end
         end
         trqs_pkg::CMD_SLP_UART: kind_tab[bwd[head]] = trqs_pkg::WK_UART;
         trqs_pkg::CMD_SLP_TMR: begin
            kind_tab[bwd[head]] = trqs_pkg::WK_TIMER;
            ticks_tab[bwd[head]] = c.intervals;
         end
         default: ;
      endcase
      r.current_thread = running;
      return r;
   endfunction

   function automatic cmd_item_type make_cmd(int cmd, int rsn, int ivl);
      cmd_item_type c;
      c.command = cmd[2:0];
      c.reason = rsn[1:0];
      c.intervals = ivl[15:0];
      return c;
   endfunction

   // Mostly well-formed traffic: creates, schedules, sleeps with short timers, wakes.
   function automatic cmd_item_type random_cmd();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 30)
         return make_cmd(trqs_pkg::CMD_SCHEDULE, $urandom_range(0, 3), $urandom);
      if (pick < 45)
         return make_cmd(trqs_pkg::CMD_CREATE, $urandom_range(0, 3), $urandom);
      if (pick < 55)
         return make_cmd(trqs_pkg::CMD_UART, $urandom_range(0, 3), $urandom);
      if (pick < 72)
         return make_cmd(trqs_pkg::CMD_TICK, $urandom_range(0, 3), $urandom);
      if (pick < 80)
         return make_cmd(trqs_pkg::CMD_SLP_UART, $urandom_range(0, 3), $urandom);
      if (pick < 92)
         return make_cmd(trqs_pkg::CMD_SLP_TMR, $urandom_range(0, 3),
                         ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 4));
      return make_cmd($urandom_range(0, 7), $urandom_range(0, 3), $urandom);
   endfunction

   // Driver: present one transfer at a time, change inputs on the falling edge.
   always @(negedge clock) begin
      if (!reset) begin
         if (!start || accepted) begin
            if (!hold_send && pending_cmds.size() > 0 &&
                $urandom_range(0, 99) >= send_idle_pct) begin
               cmd_item_type c;
               c = pending_cmds.pop_front();
               expected_results.push_back(predict_command(c));
               req_command <= c.command;
               req_reason <= c.reason;
               req_intervals <= c.intervals;
               start <= 1'b1;
            end else start <= 1'b0;
         end
      end
   end

   // Track acceptance at the rising edge.
   always @(posedge clock) begin
      accepted <= start && !busy && !reset;
   end

   // Monitor: compare each result with the oldest prediction.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("unexpected result: current_thread %0d", rsp_current_thread);
            errors = errors + 1;
         end else begin
            sched_result_type e;
            e = expected_results.pop_front();
            if (rsp_current_thread !== e.current_thread) begin
               $error("current_thread expected %0d actual %0d",
                      e.current_thread, rsp_current_thread);
               errors = errors + 1;
            end
            if (rsp_switched !== e.switched) begin
               $error("switched expected %0d actual %0d", e.switched, rsp_switched);
               errors = errors + 1;
            end
            if (rsp_created_ok !== e.created_ok) begin
               $error("created_ok expected %0d actual %0d", e.created_ok, rsp_created_ok);
               errors = errors + 1;
            end
            if (rsp_created_slot !== e.created_slot) begin
               $error("created_slot expected %0d actual %0d",
                      e.created_slot, rsp_created_slot);
               errors = errors + 1;
            end
            if (rsp_fault !== e.fault) begin
               $error("fault expected %0d actual %0d", e.fault, rsp_fault);
               errors = errors + 1;
            end
         end
      end
   end

   // Abort on a hung run.
   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   task automatic drain_queue();
      while (pending_cmds.size() > 0 || start || expected_results.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      int i;
      for (i = 0; i < NSLOT; i++) begin
         st_tab[i] = trqs_pkg::ST_FIN;
         kind_tab[i] = trqs_pkg::WK_NONE;
         ticks_tab[i] = '0;
         fwd[i] = 5'((i + 1) % NSLOT);
         bwd[i] = 5'((i + NSLOT - 1) % NSLOT);
      end
      head = '0;
      running = IDLE_SLOT;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: idle-on-idle, creates, every reason, sleeps, wakes, wrap, unused codes.
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_PREEMPT, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_CREATE, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_CREATE, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_PREEMPT, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SLP_UART, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_WAIT, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_UART, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SLP_TMR, 0, 2));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_WAIT, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SLP_TMR, 3, 16'hFFFF));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, 3, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SLP_TMR, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_WAIT, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_TICK, 0, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_FINISH, 0));
      pending_cmds.push_back(make_cmd(trqs_pkg::CMD_SCHEDULE, trqs_pkg::RSN_FINISH, 0));
      pending_cmds.push_back(make_cmd(6, 0, 0));
      pending_cmds.push_back(make_cmd(7, 3, 16'hFFFF));
      drain_queue();

      // Hold the sender while the next commands are queued, then release it.
      hold_send = 1'b1;
      for (i = 0; i < 400; i++) pending_cmds.push_back(random_cmd());
      repeat (5) @(posedge clock);
      hold_send = 1'b0;
      drain_queue();

      send_idle_pct = 67;
      for (i = 0; i < 400; i++) pending_cmds.push_back(random_cmd());
      drain_queue();

      send_idle_pct = 0;
      for (i = 0; i < 400; i++) pending_cmds.push_back(random_cmd());
      drain_queue();

      repeat (2 * NSLOT + 20) @(posedge clock);
      if (errors == 0 && expected_results.size() == 0) $display("[ OK ] regression clean");
      else $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// File: thread_run_queue_scheduler.f
src/trqs_pkg.sv
src/trqs_ctrl.sv
src/trqs_datapath.sv
src/thread_run_queue_scheduler.sv
test/thread_run_queue_scheduler_tb.sv
